FILE: rtl/msps_pkg.sv
package msps_pkg;

	localparam int SLOT_COUNT = 4;
	localparam int TIME_W     = 32;
	localparam int MASK_W     = 4;
	localparam int SLOTS_W    = 3;
	localparam int REG_IDX_W  = 3;

	typedef enum logic {
		CMD_TICK  = 1'b0,
		CMD_START = 1'b1
	} cmd_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SLOTS_IN_USE = 3'd0,
		REG_PERIOD_0     = 3'd1,
		REG_PERIOD_1     = 3'd2,
		REG_PERIOD_2     = 3'd3,
		REG_PERIOD_3     = 3'd4,
		REG_HB_ENABLE    = 3'd5,
		REG_HB_PERIOD    = 3'd6,
		REG_UNUSED       = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [SLOTS_W-1:0]                 slots_in_use;
		logic [SLOT_COUNT-1:0][TIME_W-1:0]  period;
		logic                               hb_enable;
		logic [TIME_W-1:0]                  hb_period;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0]                  prev_time;
		logic [SLOT_COUNT-1:0][TIME_W-1:0]  slot_last;
		logic [TIME_W-1:0]                  hb_last;
	} sched_state_t;

	typedef struct packed {
		logic [TIME_W-1:0] time_echo;
		logic              wrapped;
		logic [MASK_W-1:0] fire_mask;
		logic              heartbeat_fire;
	} result_t;

endpackage

FILE: rtl/msps_eval.sv
module msps_eval import msps_pkg::*; (
	input  cfg_t              cfg,
	input  sched_state_t      cur,
	input  logic              cmd,
	input  logic [TIME_W-1:0] time_now,
	output sched_state_t      nxt,
	output result_t           res
);

	logic [SLOT_COUNT-1:0] slot_en;
	logic                  rearm;
	logic                  wrap;

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			// a count above SLOT_COUNT enables every slot anyway
			slot_en[i] = cfg.slots_in_use > SLOTS_W'(i);
		end
	end

	assign wrap  = (cmd == CMD_TICK) && (time_now < cur.prev_time);
	assign rearm = (cmd == CMD_START) || wrap;

	always_comb begin
		nxt = cur;
		nxt.prev_time = time_now;
		res.time_echo = time_now;
		res.wrapped = wrap;
		res.fire_mask = '0;
		res.heartbeat_fire = 1'b0;
		if (rearm) begin
			nxt.hb_last = time_now;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (slot_en[i]) begin
					nxt.slot_last[i] = time_now;
				end
			end
		end else begin
			// elapsed time is modulo 2^32
			if (cfg.hb_enable && (time_now - cur.hb_last) > cfg.hb_period) begin
				nxt.hb_last = time_now;
				res.heartbeat_fire = 1'b1;
			end
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (slot_en[i] && (time_now - cur.slot_last[i]) > cfg.period[i]) begin
					nxt.slot_last[i] = time_now;
					res.fire_mask[i] = 1'b1;
				end
			end
		end
	end

endmodule

FILE: rtl/multi_slot_periodic_scheduler.sv
// A request accepted into the input register moves to the output register
// once the output is free; the result then holds until out_ready takes it.
// Throughput: one request per cycle; in_ready drops only while the input
// register and the output register are both full and out_ready is low.
// Reset (arst_n low, asynchronous): config, timers and valid flags cleared.
module multi_slot_periodic_scheduler import msps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd,
	input  logic [TIME_W-1:0]    time_now,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [TIME_W-1:0]    time_echo,
	output logic                 wrapped,
	output logic [MASK_W-1:0]    fire_mask,
	output logic                 heartbeat_fire
);

	cfg_t              cfg_q;
	sched_state_t      state_q;
	sched_state_t      state_nxt;
	result_t           res_nxt;
	result_t           res_q;
	logic              out_valid_q;
	logic              valid_s1;
	logic              cmd_s1;
	logic [TIME_W-1:0] time_s1;
	logic              advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SLOTS_IN_USE: cfg_q.slots_in_use <= cfg_data[SLOTS_W-1:0];
				REG_HB_ENABLE:    cfg_q.hb_enable <= cfg_data[0];
				REG_HB_PERIOD:    cfg_q.hb_period <= cfg_data;
				default: begin
					for (int i = 0; i < SLOT_COUNT; i++) begin
						if (cfg_index == REG_IDX_W'(REG_PERIOD_0 + i)) begin
							cfg_q.period[i] <= cfg_data;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1  <= cmd;
			time_s1 <= time_now;
		end
	end

	msps_eval u_eval (
		.cfg      (cfg_q),
		.cur      (state_q),
		.cmd      (cmd_s1),
		.time_now (time_s1),
		.nxt      (state_nxt),
		.res      (res_nxt)
	);

	// timers move only when the request leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign time_echo      = res_q.time_echo;
	assign wrapped        = res_q.wrapped;
	assign fire_mask      = res_q.fire_mask;
	assign heartbeat_fire = res_q.heartbeat_fire;

endmodule

FILE: rtl/msps_checker.sv
module msps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] time_echo,
	input logic        wrapped,
	input logic [3:0]  fire_mask,
	input logic        heartbeat_fire
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(time_echo) && $stable(fire_mask))
		else $error("result changed while stalled");

	// a wrap re-arms and fires nothing
	a_wrap_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && wrapped |-> fire_mask == 4'd0 && !heartbeat_fire)
		else $error("fire reported on a wrap");

	// back-pressure only while a result waits
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with output free");

	// an accepted request is followed by a valid output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("accepted request produced no result");

endmodule

bind multi_slot_periodic_scheduler msps_checker u_msps_checker (.*);
